// File: hw/rtl/b64lw_pkg.sv
package b64lw_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned SextetW  = 6;
  localparam int unsigned MaxItems = 4;
  localparam int unsigned CountW   = $clog2(MaxItems + 1);

  localparam logic [ByteW-1:0] NlChar      = 8'h0A;
  localparam logic [ByteW-1:0] LineLenRst  = 8'd72;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2,
    PH_SPARE  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] col;
    logic [3:0]       left;
    phase_e           phase;
  } enc_state_t;

  typedef struct packed {
    logic [MaxItems-1:0][ByteW-1:0] chars;
    logic [CountW-1:0]              count;
    enc_state_t                     nxt;
  } enc_out_t;

  function automatic logic [ByteW-1:0] b64_char(input logic [SextetW-1:0] s);
    logic [ByteW-1:0] v;
    v = {2'b00, s};
    if (s < 6'd26) begin
      return 8'h41 + v;
    end else if (s < 6'd52) begin
      return 8'h61 + v - 8'd26;
    end else if (s < 6'd62) begin
      return 8'h30 + v - 8'd52;
    end else if (s == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

// File: hw/rtl/base64_line_wrapping_encoder_core.sv
// Base64 encoder with line wrapping.
// Input stream: one raw byte per request on s_axis_tdata, s_axis_tlast marks the
// final byte of a stream, which flushes the partial sextet zero-filled (no padding).
// Output stream: one ASCII character per request on m_axis_tdata; a newline 0x0A
// follows whenever the column count reaches line_length_i's stored value.
// m_axis_tlast marks the last character produced by an input byte.
// Each input byte yields one to four characters, written into a four-entry output
// buffer the cycle it is accepted; the first character is valid the next cycle.
// The buffer drains one character per cycle while m_axis_tready is high, and an input
// byte occupies the block until all of its characters have been taken.
// A new byte is taken while the last buffered character is being taken.
// If the receiver stalls, the buffer holds and s_axis_tready stays low while any
// character is pending and not being taken.
// Reset clears phase, leftover bits, column count and buffer count, and sets the line
// length to 72. line_length_we_i writes the length; write it only when idle.
module base64_line_wrapping_encoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       line_length_we_i,
  input  logic [7:0] line_length_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // final_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast    // run_last
);
  import b64lw_pkg::*;

  logic [ByteW-1:0]               len_q;
  enc_state_t                     st_q, st_d;
  logic [MaxItems-1:0][ByteW-1:0] buf_q, buf_d;
  logic [CountW-1:0]              cnt_q, cnt_d;
  enc_out_t                       enc;
  logic                           in_acc, out_acc;

  b64lw_encode u_encode (
    .data_byte_i  (s_axis_tdata),
    .final_byte_i (s_axis_tlast),
    .line_length_i(len_q),
    .state_i      (st_q),
    .enc_o        (enc)
  );

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = buf_q[0];
  assign m_axis_tlast  = (cnt_q == CountW'(1));
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q == '0) || (m_axis_tlast && m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    st_d  = st_q;
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (in_acc) begin
      st_d  = enc.nxt;
      buf_d = enc.chars;
      cnt_d = enc.count;
    end else if (out_acc) begin
      for (int i = 0; i < MaxItems - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      cnt_d = cnt_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LineLenRst;
      st_q  <= '{col: '0, left: '0, phase: PH_FIRST};
      cnt_q <= '0;
    end else begin
      if (line_length_we_i) begin
        len_q <= line_length_i;
      end
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountW'(MaxItems))
    else $error("output buffer count out of range");

  a_acc_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_axis_tvalid)
    else $error("accepted byte produced no character");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (cnt_q == '0 || (cnt_q == CountW'(1) && out_acc)))
    else $error("byte accepted over pending characters");

  a_phase_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (st_q.phase == PH_FIRST && st_q.left == 4'd0))
    else $error("final byte did not clear phase");

endmodule

// File: hw/rtl/b64lw_encode.sv
module b64lw_encode (
  input  logic [7:0]             data_byte_i,
  input  logic                   final_byte_i,
  input  logic [7:0]             line_length_i,
  input  b64lw_pkg::enc_state_t  state_i,
  output b64lw_pkg::enc_out_t    enc_o
);
  import b64lw_pkg::*;

  logic [SextetW-1:0] sx0, sx1;
  logic               two;
  logic [3:0]         left_nxt;
  phase_e             phase_nxt;
  logic [ByteW-1:0]   c1, c2, col_mid;
  logic               nl0, nl1;
  logic [CountW-1:0]  n;

  always_comb begin
    sx0       = data_byte_i[7:2];
    sx1       = {state_i.left[1:0] & 2'b00, 4'b0000};
    two       = final_byte_i;
    left_nxt  = {2'b00, data_byte_i[1:0]};
    phase_nxt = PH_SECOND;
    unique case (state_i.phase)
      PH_SECOND: begin
        sx0       = {state_i.left[1:0], data_byte_i[7:4]};
        sx1       = {data_byte_i[3:0], 2'b00};
        two       = final_byte_i;
        left_nxt  = data_byte_i[3:0];
        phase_nxt = PH_THIRD;
      end
      PH_THIRD: begin
        sx0       = {state_i.left, data_byte_i[7:6]};
        sx1       = data_byte_i[5:0];
        two       = 1'b1;
        left_nxt  = 4'd0;
        phase_nxt = PH_FIRST;
      end
      default: begin
        sx0       = data_byte_i[7:2];
        sx1       = {data_byte_i[1:0], 4'b0000};
        two       = final_byte_i;
        left_nxt  = {2'b00, data_byte_i[1:0]};
        phase_nxt = PH_SECOND;
      end
    endcase
    if (final_byte_i) begin
      left_nxt  = 4'd0;
      phase_nxt = PH_FIRST;
    end
  end

  always_comb begin
    c1      = state_i.col + 8'd1;
    nl0     = (c1 >= line_length_i);
    col_mid = nl0 ? 8'd0 : c1;
    c2      = col_mid + 8'd1;
    nl1     = (c2 >= line_length_i);
  end

  always_comb begin
    enc_o       = '0;
    n           = '0;
    enc_o.chars[n[1:0]] = b64_char(sx0);
    n           = n + 3'd1;
    if (nl0) begin
      enc_o.chars[n[1:0]] = NlChar;
      n = n + 3'd1;
    end
    if (two) begin
      enc_o.chars[n[1:0]] = b64_char(sx1);
      n = n + 3'd1;
      if (nl1) begin
        enc_o.chars[n[1:0]] = NlChar;
        n = n + 3'd1;
      end
    end
    enc_o.count     = n;
    enc_o.nxt.left  = left_nxt;
    enc_o.nxt.phase = phase_nxt;
    if (two) begin
      enc_o.nxt.col = nl1 ? 8'd0 : c2;
    end else begin
      enc_o.nxt.col = col_mid;
    end
  end

endmodule
